@@ sv/bror_pkg.sv @@
// Shared types and constants for the broadcast ring with overrun resync.
package bror_pkg;

	// Default sizes handed to the top level parameters
	localparam int RING_DEPTH_DEF = 256;
	localparam int NUM_SUBS_DEF   = 8;
	localparam int WORD_BITS_DEF  = 32;

	// Fixed field widths
	localparam int CNT_BITS       = 32;
	localparam int OP_BITS        = 2;
	localparam int SUB_BITS       = 3;
	localparam int DATA_BITS      = 32;
	localparam int CFG_IDX_BITS   = 1;
	localparam int CFG_DATA_BITS  = 16;
	localparam int DEPTH_CFG_BITS = 9;
	localparam int MODE_CFG_BITS  = 16;
	localparam int MODE_BITS      = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODES = 1'b1;

	typedef enum logic [OP_BITS-1:0] {
		OP_PUBLISH = 2'd0,
		OP_POLL    = 2'd1,
		OP_PEEK    = 2'd2
	} op_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_NEW    = 2'd0,
		MODE_OLDEST = 2'd1,
		MODE_NEWEST = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DIVIDE,
		ST_FETCH
	} state_t;

endpackage

@@ sv/bror_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bror_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/bror_urem.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module bror_urem #(
	parameter int NUM_BITS = 8,
	parameter int DEN_BITS = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] dividend,
	input  logic [DEN_BITS-1:0] divisor,
	output logic                done,
	output logic [DEN_BITS-1:0] remainder
);

	localparam int CW = $clog2(NUM_BITS + 1);

	logic                running_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   trial_sub;
	logic [DEN_BITS-1:0] rem_next;

	// Shift in the next dividend bit and subtract when it fits
	always_comb begin
		trial     = {rem_q, num_q[NUM_BITS-1]};
		trial_sub = trial - {1'b0, divisor};
		rem_next  = (trial >= {1'b0, divisor}) ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= CW'(NUM_BITS);
			end else if (running_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	// Load operands, then advance one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (running_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ sv/broadcast_ring_with_overrun_resync_unit.sv @@
// Top level of the broadcast ring: one publisher, several subscribers, overrun resync.
// Publish, unused op or poll/peek of an out-of-range subscriber: result registered in the cycle
// after start, busy stays low, one item per cycle. Poll/peek: subscriber RAM read, ring RAM read,
// output register; an empty report skips the ring read. The next start is taken once busy drops.
// Oldest-entry resync before depth words were published adds a remainder step. Receiver cannot stall.
// Reset zeroes positions, counts, modes, sets depth RING_DEPTH; unwritten subscriber entries read 0.
module broadcast_ring_with_overrun_resync_unit #(
	parameter int RING_DEPTH      = bror_pkg::RING_DEPTH_DEF,
	parameter int NUM_SUBSCRIBERS = bror_pkg::NUM_SUBS_DEF,
	parameter int WORD_BITS       = bror_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [bror_pkg::OP_BITS-1:0]        op,
	input  logic [bror_pkg::SUB_BITS-1:0]       subscriber,
	input  logic [bror_pkg::DATA_BITS-1:0]      data_word,
	output logic                                done,
	output logic                                status,
	output logic [bror_pkg::DATA_BITS-1:0]      read_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bror_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bror_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	import bror_pkg::*;

	localparam int PW         = $clog2(RING_DEPTH);
	localparam int DRAW       = $clog2(RING_DEPTH + 1);
	localparam int DW         = DRAW > DEPTH_CFG_BITS ? DRAW : DEPTH_CFG_BITS;
	localparam int SW         = NUM_SUBSCRIBERS > 1 ? $clog2(NUM_SUBSCRIBERS) : 1;
	localparam int XW         = SW > SUB_BITS ? SW : SUB_BITS;
	localparam int STORE_BITS = WORD_BITS < DATA_BITS ? WORD_BITS : DATA_BITS;
	localparam int ENTRY_BITS = PW + CNT_BITS;

	// Wrap a position at the depth in use
	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [DW-1:0] d);
		logic [DW-1:0] n;
		n = DW'(p) + DW'(1);
		return (n >= d) ? '0 : n[PW-1:0];
	endfunction

	state_t                 state_q, state_d;
	logic [DW-1:0]          depth_cfg_q;
	logic [MODE_CFG_BITS-1:0] modes_q;
	logic [PW-1:0]          wp_q;
	logic [CNT_BITS-1:0]    pc_q;
	op_t                    op_q;
	logic [SUB_BITS-1:0]    sub_q;
	logic [SW-1:0]          sub_addr_q;
	logic [NUM_SUBSCRIBERS-1:0] sub_valid_q;
	logic [PW-1:0]          rp_q;
	logic [CNT_BITS-1:0]    nrc_q;
	logic                   done_q;
	logic                   status_q;
	logic [DATA_BITS-1:0]   read_data_q;

	logic [DW-1:0]          depth;
	logic [XW-1:0]          sub_x;
	logic [SW-1:0]          sub_addr;
	logic                   sub_ok;
	op_t                    op_in;

	logic                   ring_we, ring_re;
	logic [PW-1:0]          ring_raddr;
	logic [STORE_BITS-1:0]  ring_rdata;
	logic                   sub_we, sub_re;
	logic [PW-1:0]          sub_wrp;
	logic [CNT_BITS-1:0]    sub_wnrc;
	logic [ENTRY_BITS-1:0]  sub_rdata;

	logic [PW-1:0]          rp_cur, rp_look, rp_div;
	logic [CNT_BITS-1:0]    nrc_cur, nrc_look;
	logic [CNT_BITS-1:0]    diff_cur, diff_look;
	logic                   lapped, need_div, look_empty;
	mode_t                  mode;
	logic [DW:0]            div_sum, div_sum_sub;
	logic                   mod_start, mod_done;
	logic [DW-1:0]          mod_rem;

	logic                   work_load;
	logic [PW-1:0]          work_rp;
	logic [CNT_BITS-1:0]    work_nrc;
	logic                   out_load, out_status, out_from_ring;

	// Clamp the configured depth to the usable range
	always_comb begin
		if (depth_cfg_q == '0) begin
			depth = DW'(1);
		end else if (depth_cfg_q > DW'(RING_DEPTH)) begin
			depth = DW'(RING_DEPTH);
		end else begin
			depth = depth_cfg_q;
		end
	end

	// Decode the incoming item
	assign op_in    = op_t'(op);
	assign sub_x    = XW'(subscriber);
	assign sub_addr = sub_x[SW-1:0];
	assign sub_ok   = 32'(subscriber) < NUM_SUBSCRIBERS;

	// Subscriber entry as read back; an unwritten entry reads as zero
	assign rp_cur  = sub_valid_q[sub_addr_q] ? sub_rdata[ENTRY_BITS-1:CNT_BITS] : '0;
	assign nrc_cur = sub_valid_q[sub_addr_q] ? sub_rdata[CNT_BITS-1:0] : '0;
	assign mode    = mode_t'(modes_q[{sub_q, 1'b0} +: MODE_BITS]);

	// Detect overrun and resync the read position by mode
	always_comb begin
		diff_cur = pc_q - nrc_cur;
		lapped   = diff_cur > CNT_BITS'(depth);
		need_div = 1'b0;
		rp_look  = rp_cur;
		nrc_look = nrc_cur;
		if (lapped) begin
			case (mode)
				MODE_OLDEST: begin
					if (pc_q >= CNT_BITS'(depth)) begin
						rp_look  = wp_q;
						nrc_look = pc_q - CNT_BITS'(depth);
					end else begin
						need_div = 1'b1;
					end
				end
				MODE_NEWEST: begin
					nrc_look = pc_q - CNT_BITS'(1);
					rp_look  = (wp_q == '0) ? PW'(depth - DW'(1)) : wp_q - PW'(1);
				end
				default: begin
					rp_look  = wp_q;
					nrc_look = pc_q;
				end
			endcase
		end
		diff_look  = pc_q - nrc_look;
		look_empty = (diff_look == '0);
	end

	// Oldest kept entry: (write position mod depth + depth - publish count) mod depth
	always_comb begin
		div_sum     = {1'b0, mod_rem} + {1'b0, depth} - {1'b0, pc_q[DW-1:0]};
		div_sum_sub = div_sum - {1'b0, depth};
		rp_div      = (div_sum >= {1'b0, depth}) ? div_sum_sub[PW-1:0] : div_sum[PW-1:0];
	end

	// Sequencer: next state and memory controls
	always_comb begin
		state_d       = state_q;
		ring_we       = 1'b0;
		ring_re       = 1'b0;
		ring_raddr    = rp_look;
		sub_re        = 1'b0;
		sub_we        = 1'b0;
		sub_wrp       = rp_q;
		sub_wnrc      = nrc_q;
		work_load     = 1'b0;
		work_rp       = rp_look;
		work_nrc      = nrc_look;
		mod_start     = 1'b0;
		out_load      = 1'b0;
		out_status    = 1'b1;
		out_from_ring = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op_in)
						OP_PUBLISH: begin
							ring_we    = 1'b1;
							out_load   = 1'b1;
							out_status = 1'b0;
						end
						OP_POLL, OP_PEEK: begin
							if (sub_ok) begin
								sub_re  = 1'b1;
								state_d = ST_LOOKUP;
							end else begin
								out_load = 1'b1;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			ST_LOOKUP: begin
				if (need_div) begin
					mod_start = 1'b1;
					state_d   = ST_DIVIDE;
				end else if (look_empty) begin
					sub_we   = 1'b1;
					sub_wrp  = rp_look;
					sub_wnrc = nrc_look;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					ring_re   = 1'b1;
					work_load = 1'b1;
					state_d   = ST_FETCH;
				end
			end
			ST_DIVIDE: begin
				if (mod_done) begin
					if (pc_q == '0) begin
						sub_we   = 1'b1;
						sub_wrp  = rp_div;
						sub_wnrc = '0;
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						ring_re    = 1'b1;
						ring_raddr = rp_div;
						work_load  = 1'b1;
						work_rp    = rp_div;
						work_nrc   = '0;
						state_d    = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				sub_we = 1'b1;
				if (op_q == OP_POLL) begin
					sub_wrp  = advance(rp_q, depth);
					sub_wnrc = nrc_q + CNT_BITS'(1);
				end
				out_load      = 1'b1;
				out_status    = 1'b0;
				out_from_ring = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Publisher position and count, subscriber valid bits, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			pc_q        <= '0;
			sub_valid_q <= '0;
			done_q      <= 1'b0;
		end else begin
			if (ring_we) begin
				wp_q <= advance(wp_q, depth);
				pc_q <= pc_q + CNT_BITS'(1);
			end
			if (sub_we) begin
				sub_valid_q[sub_addr_q] <= 1'b1;
			end
			done_q <= out_load;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_cfg_q <= DW'(RING_DEPTH);
			modes_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEPTH: depth_cfg_q <= DW'(cfg_data[DEPTH_CFG_BITS-1:0]);
				REG_MODES: modes_q <= cfg_data[MODE_CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Hold the item and the working read position
	always_ff @(posedge clk) begin
		if (sub_re) begin
			op_q       <= op_in;
			sub_q      <= subscriber;
			sub_addr_q <= sub_addr;
		end
		if (work_load) begin
			rp_q  <= work_rp;
			nrc_q <= work_nrc;
		end
		if (out_load) begin
			status_q    <= out_status;
			read_data_q <= out_from_ring ? DATA_BITS'(ring_rdata) : '0;
		end
	end

	// Ring word store
	bror_ram #(
		.WIDTH(STORE_BITS),
		.DEPTH(RING_DEPTH)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(wp_q),
		.wdata(data_word[STORE_BITS-1:0]),
		.re   (ring_re),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	// Per-subscriber read position and next read count
	bror_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(NUM_SUBSCRIBERS)
	) u_sub_ram (
		.clk  (clk),
		.we   (sub_we),
		.waddr(sub_addr_q),
		.wdata({sub_wrp, sub_wnrc}),
		.re   (sub_re),
		.raddr(sub_addr),
		.rdata(sub_rdata)
	);

	// Write position modulo depth for the oldest-entry resync
	bror_urem #(
		.NUM_BITS(PW),
		.DEN_BITS(DW)
	) u_urem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (wp_q),
		.divisor  (depth),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	// Take register writes only with no item in flight or arriving
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy && !start;
	assign done      = done_q;
	assign status    = status_q;
	assign read_data = read_data_q;

endmodule

@@ sim/tb_broadcast_ring_with_overrun_resync_unit.sv @@
// Testbench for the broadcast ring: directed and random publish/poll/peek traffic, self-checked.
module tb_broadcast_ring_with_overrun_resync_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import bror_pkg::*;

	localparam int SLOTS      = RING_DEPTH_DEF;
	localparam int SUBS       = NUM_SUBS_DEF;
	localparam int SETTLE     = 16;
	localparam int LIMIT      = 400000;
	localparam int SEGMENTS   = 8;
	localparam int SEG_WORDS  = 250;
	localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic                 status;
		logic [DATA_BITS-1:0] data;
	} delivery_t;

	// Track ring contents, pointers and settings; predict one delivery per accepted word
	class ring_delivery_board;
		logic [DATA_BITS-1:0] ring_words [SLOTS];
		bit                   written [SLOTS];
		bit [7:0]             wr_pos;
		bit [31:0]            pub_cnt;
		bit [7:0]             rd_pos [SUBS];
		bit [31:0]            rd_cnt [SUBS];
		bit [8:0]             depth_reg;
		bit [15:0]            modes_reg;
		delivery_t            pending [$];
		int                   errors, n_results, n_pub, n_poll, n_peek, n_empty, n_resync;

		function new();
			wr_pos    = '0;
			pub_cnt   = '0;
			depth_reg = 9'(SLOTS);
			modes_reg = '0;
			foreach (rd_pos[i]) begin
				rd_pos[i] = '0;
				rd_cnt[i] = '0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
			if (idx == REG_DEPTH)
				depth_reg = val[DEPTH_CFG_BITS-1:0];
			else
				modes_reg = val;
		endfunction

		// Clamp the depth register into 1..SLOTS
		function int unsigned depth();
			int unsigned d;
			d = depth_reg;
			if (d < 1) d = 1;
			if (d > SLOTS) d = SLOTS;
			return d;
		endfunction

		function bit [7:0] advance(bit [7:0] pos, int unsigned dep);
			int unsigned nxt;
			nxt = pos + 1;
			return (nxt >= dep) ? 8'd0 : 8'(nxt);
		endfunction

		// Work out where a subscriber reads next, resyncing first if it was lapped
		function void locate(int unsigned s, output bit [7:0] pos, output bit [31:0] cnt,
				output bit resynced);
			int unsigned dep;
			bit [31:0]   lag, wr32;
			logic [1:0]  mode;
			dep      = depth();
			pos      = rd_pos[s];
			cnt      = rd_cnt[s];
			resynced = 1'b0;
			lag      = pub_cnt - cnt;
			mode     = modes_reg[2*s +: 2];
			wr32     = wr_pos;
			if (lag > dep) begin
				resynced = 1'b1;
				case (mode)
					MODE_OLDEST: begin
						if (pub_cnt >= dep) begin
							pos = wr_pos;
							cnt = pub_cnt - dep;
						end else begin
							pos = 8'((wr32 % dep + dep - pub_cnt) % dep);
							cnt = '0;
						end
					end
					MODE_NEWEST: begin
						cnt = pub_cnt - 1;
						pos = (wr_pos == 0) ? 8'(dep - 1) : wr_pos - 8'd1;
					end
					default: begin
						pos = wr_pos;
						cnt = pub_cnt;
					end
				endcase
			end
		endfunction

		// Tell whether a read for this subscriber would land on a never-written slot
		function bit reads_blank(int unsigned s);
			bit [7:0]  pos;
			bit [31:0] cnt;
			bit        rs;
			locate(s, pos, cnt, rs);
			return (cnt != pub_cnt) && !written[pos];
		endfunction

		// Apply an accepted word and queue the delivery it causes
		function void note_word(logic [OP_BITS-1:0] o, logic [SUB_BITS-1:0] s,
				logic [DATA_BITS-1:0] d);
			delivery_t   e;
			bit [7:0]    pos;
			bit [31:0]   cnt;
			bit          rs;
			int unsigned dep;
			dep      = depth();
			e.status = 1'b1;
			e.data   = '0;
			if (o == OP_PUBLISH) begin
				ring_words[wr_pos] = d;
				written[wr_pos]    = 1'b1;
				wr_pos             = advance(wr_pos, dep);
				pub_cnt            = pub_cnt + 1;
				e.status           = 1'b0;
				n_pub++;
			end else if (o == OP_POLL || o == OP_PEEK) begin
				locate(s, pos, cnt, rs);
				rd_pos[s] = pos;
				rd_cnt[s] = cnt;
				n_resync += rs;
				if (cnt != pub_cnt) begin
					e.status = 1'b0;
					e.data   = ring_words[pos];
					if (o == OP_POLL) begin
						rd_pos[s] = advance(pos, dep);
						rd_cnt[s] = cnt + 1;
						n_poll++;
					end else begin
						n_peek++;
					end
				end else begin
					n_empty++;
				end
			end
			pending.push_back(e);
		endfunction

		// Compare one delivery with the oldest prediction
		function void check_result(logic st, logic [DATA_BITS-1:0] rd);
			delivery_t e;
			if (pending.size() == 0) begin
				$error("result with nothing outstanding: status %0d read_data %h", st, rd);
				errors++;
				return;
			end
			e = pending.pop_front();
			n_results++;
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (rd !== e.data) begin
				$error("read_data: expected %h, got %h", e.data, rd);
				errors++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [OP_BITS-1:0]       op = OP_PUBLISH;
	logic [SUB_BITS-1:0]      subscriber = '0;
	logic [DATA_BITS-1:0]     data_word = '0;
	logic                     done;
	logic                     status;
	logic [DATA_BITS-1:0]     read_data;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = REG_DEPTH;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	ring_delivery_board board = new();
	int                 cycles = 0;

	broadcast_ring_with_overrun_resync_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.subscriber (subscriber),
		.data_word  (data_word),
		.done       (done),
		.status     (status),
		.read_data  (read_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Check each delivery strobe; stop the run at the cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			board.check_result(status, read_data);
		if (cycles > LIMIT) begin
			$display("broadcast_ring_with_overrun_resync_unit verification failed");
			$finish;
		end
	end

	// Present one word and hold it until the block takes it
	task automatic issue(input logic [OP_BITS-1:0] o, input logic [SUB_BITS-1:0] s,
			input logic [DATA_BITS-1:0] d);
		op         <= o;
		subscriber <= s;
		data_word  <= d;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		board.note_word(o, s, d);
	endtask

	// Hold a register write until the channel takes it
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
	endtask

	task automatic configure(input logic [DEPTH_CFG_BITS-1:0] dep,
			input logic [MODE_CFG_BITS-1:0] modes);
		write_reg(REG_DEPTH, {7'($urandom), dep});
		write_reg(REG_MODES, modes);
		cfg_valid <= 1'b0;
	endtask

	// Wait out every outstanding delivery plus the slowest resync
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Pick a random word; turn a read of a never-written slot into a publish
	task automatic random_item(input int pub_pct);
		int                  roll;
		logic [OP_BITS-1:0]  o;
		logic [SUB_BITS-1:0] s;
		roll = $urandom_range(99);
		s    = 3'($urandom_range(SUBS - 1));
		if (roll < pub_pct)
			o = OP_PUBLISH;
		else if (roll < 95)
			o = ($urandom_range(99) < 70) ? OP_POLL : OP_PEEK;
		else
			o = OP_UNUSED;
		if ((o == OP_POLL || o == OP_PEEK) && board.reads_blank(s))
			o = OP_PUBLISH;
		issue(o, s, $urandom);
	endtask

	initial begin
		int                        seg, idle_pct, pub_pct;
		logic [DEPTH_CFG_BITS-1:0] dep;
		logic [MODE_CFG_BITS-1:0]  modes;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty reads, unused op and full-range data at reset settings
		issue(OP_PEEK, 3'd0, '0);
		issue(OP_POLL, 3'd7, '0);
		issue(OP_UNUSED, 3'd0, '0);
		issue(OP_PUBLISH, 3'd0, 32'h0000_0000);
		issue(OP_PUBLISH, 3'd7, 32'hFFFF_FFFF);
		issue(OP_PUBLISH, 3'd3, 32'h8000_0001);
		issue(OP_PEEK, 3'd0, '0);
		issue(OP_POLL, 3'd0, '0);
		issue(OP_POLL, 3'd0, '0);
		issue(OP_POLL, 3'd0, '0);
		issue(OP_POLL, 3'd0, '0);
		issue(OP_UNUSED, 3'd7, 32'hFFFF_FFFF);
		start <= 1'b0;
		drain();

		// Shrink to two slots below the write pointer, lap everyone, then read each mode
		configure(9'd2, 16'hC9E4);
		repeat (5) issue(OP_PUBLISH, 3'($urandom), $urandom);
		issue(OP_PEEK, 3'd1, '0);
		issue(OP_POLL, 3'd1, '0);
		issue(OP_POLL, 3'd2, '0);
		issue(OP_POLL, 3'd3, '0);
		issue(OP_POLL, 3'd0, '0);
		issue(OP_PEEK, 3'd4, '0);
		issue(OP_POLL, 3'd5, '0);
		issue(OP_POLL, 3'd7, '0);
		start <= 1'b0;

		// Random traffic over several depth and mode settings
		for (seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			case (seg)
				0: begin dep = 9'd0;   modes = 16'h0000; end
				1: begin dep = 9'd1;   modes = 16'hFFFF; end
				2: begin dep = 9'd2;   modes = 16'h5555; end
				3: begin dep = 9'd256; modes = 16'hAAAA; end
				4: begin dep = 9'd511; modes = 16'($urandom); end
				5: begin dep = 9'($urandom_range(3, 16)); modes = 16'($urandom); end
				6: begin dep = 9'($urandom_range(1, 256)); modes = 16'hC9E4; end
				default: begin dep = 9'd257; modes = 16'($urandom); end
			endcase
			configure(dep, modes);
			idle_pct = (seg < 3) ? 15 : ((seg < 6) ? 62 : 0);
			pub_pct  = $urandom_range(35, 70);
			repeat (SEG_WORDS) begin
				random_item(pub_pct);
				if ($urandom_range(99) < idle_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
			end
			start <= 1'b0;
		end

		drain();
		$display("Checked %0d deliveries: %0d publishes, %0d polls, %0d peeks, %0d empty reads,",
			board.n_results, board.n_pub, board.n_poll, board.n_peek, board.n_empty);
		$display("%0d overrun resyncs, over %0d depth/mode settings.",
			board.n_resync, SEGMENTS + 2);
		if (board.errors == 0)
			$display("broadcast_ring_with_overrun_resync_unit verification clean");
		else
			$display("broadcast_ring_with_overrun_resync_unit verification failed");
		$finish;
	end

endmodule
